// ===== hdl/mct_pkg.sv =====
// Shared types, Morse code table and lookup functions for the Morse translator.
package mct_pkg;

    // Table geometry: only the first TABLE_ENTRIES slots are searched.
    localparam int TABLE_ENTRIES  = 36;
    localparam int CODE_SLOTS     = 36;
    localparam int ACTIVE_ENTRIES = (TABLE_ENTRIES < CODE_SLOTS) ? TABLE_ENTRIES : CODE_SLOTS;
    localparam int MAX_SYMBOLS    = 5;
    localparam int SYM_W          = MAX_SYMBOLS;
    localparam int LEN_W          = $clog2(MAX_SYMBOLS + 1);
    localparam int IDX_W          = $clog2(CODE_SLOTS);

    // Job queue between front and back; depth must be a power of two.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Character codes
    localparam logic [7:0] CHAR_A     = 8'h41;
    localparam logic [7:0] CHAR_Z     = 8'h5A;
    localparam logic [7:0] CHAR_LA    = 8'h61;
    localparam logic [7:0] CHAR_LZ    = 8'h7A;
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_1     = 8'h31;
    localparam logic [7:0] CHAR_9     = 8'h39;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_DASH  = 8'h2D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CASE_GAP   = 8'h20;
    localparam logic [7:0] DIGIT_BASE = 8'd26;
    localparam logic [IDX_W-1:0] ZERO_INDEX = IDX_W'(35);

    typedef enum logic [1:0] {
        KIND_DOT     = 2'd0,
        KIND_DASH    = 2'd1,
        KIND_CHAR    = 2'd2,
        KIND_INVALID = 2'd3
    } kind_t;

    // One unit of work for the back end: a symbol run or a single result.
    typedef struct packed {
        logic             is_sym;
        logic [SYM_W-1:0] sym_bits;
        logic [LEN_W-1:0] sym_len;
        kind_t            kind;
        logic [7:0]       ch;
    } job_t;

    // Bit i set means symbol i is a dash.
    localparam logic [SYM_W-1:0] CODE_BITS [CODE_SLOTS] = '{
        5'b00010, 5'b00001, 5'b00101, 5'b00001, 5'b00000, 5'b00100,
        5'b00011, 5'b00000, 5'b00000, 5'b01110, 5'b00101, 5'b00010,
        5'b00011, 5'b00001, 5'b00111, 5'b00110, 5'b01011, 5'b00010,
        5'b00000, 5'b00001, 5'b00100, 5'b01000, 5'b00110, 5'b01001,
        5'b01101, 5'b00011, 5'b11110, 5'b11100, 5'b11000, 5'b10000,
        5'b00000, 5'b00001, 5'b00011, 5'b00111, 5'b01111, 5'b11111
    };

    localparam logic [LEN_W-1:0] CODE_LEN [CODE_SLOTS] = '{
        3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4,
        3'd3, 3'd4, 3'd2, 3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1,
        3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4, 3'd5, 3'd5, 3'd5, 3'd5,
        3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5
    };

    localparam logic [7:0] LETTER [CODE_SLOTS] = '{
        8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48, 8'h49,
        8'h4A, 8'h4B, 8'h4C, 8'h4D, 8'h4E, 8'h4F, 8'h50, 8'h51, 8'h52,
        8'h53, 8'h54, 8'h55, 8'h56, 8'h57, 8'h58, 8'h59, 8'h5A,
        8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h30
    };

    // Fold lowercase letters onto uppercase; leave all else alone.
    function automatic logic [7:0] to_upper(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= CHAR_LA && c <= CHAR_LZ)
            r = c - CASE_GAP;
        return r;
    endfunction

    // Map an uppercase byte to its table slot; top bit flags a hit.
    function automatic logic [IDX_W:0] encode_index(input logic [7:0] c);
        logic             hit;
        logic [IDX_W-1:0] idx;
        logic [7:0]       diff;
        hit  = 1'b0;
        idx  = '0;
        diff = '0;
        if (c >= CHAR_A && c <= CHAR_Z) begin
            diff = c - CHAR_A;
            idx  = diff[IDX_W-1:0];
            hit  = 1'b1;
        end else if (c >= CHAR_1 && c <= CHAR_9) begin
            diff = DIGIT_BASE + (c - CHAR_1);
            idx  = diff[IDX_W-1:0];
            hit  = 1'b1;
        end else if (c == CHAR_0) begin
            idx  = ZERO_INDEX;
            hit  = 1'b1;
        end
        if (int'(idx) >= ACTIVE_ENTRIES)
            hit = 1'b0;
        return {hit, idx};
    endfunction

    // Match a gathered token against the table; top bit flags a hit.
    function automatic logic [8:0] decode_lookup(input logic [SYM_W-1:0] bits,
                                                 input logic [LEN_W-1:0] len);
        logic       hit;
        logic [7:0] letter;
        hit    = 1'b0;
        letter = '0;
        for (int i = 0; i < ACTIVE_ENTRIES; i++) begin
            if (!hit && CODE_LEN[i] == len && CODE_BITS[i] == bits) begin
                hit    = 1'b1;
                letter = LETTER[i];
            end
        end
        return {hit, letter};
    endfunction

endpackage

// ===== hdl/morse_code_translator_top.sv =====
// Top level of the ASCII/Morse translator: front end, job queue and back end.
//
// Input channel (in_valid/in_ready, char_in, end_of_message) takes one byte per
// transfer. Output channel (out_valid/out_ready, kind, char_out, last) gives one
// result per transfer; last marks the final result of a byte.
// cfg_we/cfg_wdata write the mode bit (0 encode, 1 decode); the user must write
// it only while idle, which the block does not enforce. A byte's job goes to the
// job queue and its results to the output register. The front end takes one
// byte per cycle while the four-entry job queue has room; the back end emits one
// result per cycle from its output register while the receiver takes them, so an
// encoded character gives one result per symbol (1 to 5) and a decode close one.
// Reset clears mode, token and halt state, empties the queue and clears out_valid.
// When the receiver stalls, the output register holds its result, the queue
// fills, and in_ready drops once the queue is full.
module morse_code_translator_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] char_in,
    input  logic       end_of_message,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] kind,
    output logic [7:0] char_out,
    output logic       last
);
    import mct_pkg::*;

    logic push_valid;
    job_t push_job;
    job_t head_job;
    logic q_full;
    logic q_empty;
    logic pop;

    mct_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .char_in        (char_in),
        .end_of_message (end_of_message),
        .q_full         (q_full),
        .push_valid     (push_valid),
        .push_job       (push_job)
    );

    mct_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push_valid),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .full     (q_full),
        .empty    (q_empty)
    );

    mct_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_job  (head_job),
        .q_empty   (q_empty),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .kind      (kind),
        .char_out  (char_out),
        .last      (last)
    );

`ifndef SYNTHESIS
    // A free output slot with nothing queued must not produce a result
    assert property (@(posedge clk) disable iff (!rst_n)
        ((!out_valid || out_ready) && q_empty) |=> !out_valid)
        else $error("result appeared with no queued job");

    // Decoded and invalid results are always the last of their byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (kind == KIND_CHAR || kind == KIND_INVALID)) |-> last)
        else $error("single result not marked last");

    // Dots and dashes carry no character
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (kind == KIND_DOT || kind == KIND_DASH)) |-> (char_out == 8'd0))
        else $error("symbol result carries a character");
`endif

endmodule

// ===== hdl/mct_front.sv =====
// Front end: takes input bytes, tracks token and halt state, issues jobs.
module mct_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic          cfg_wdata,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [7:0]    char_in,
    input  logic          end_of_message,
    input  logic          q_full,
    output logic          push_valid,
    output mct_pkg::job_t push_job
);
    import mct_pkg::*;

    logic             mode_reg, mode_next;
    logic [SYM_W-1:0] token_bits_reg, token_bits_next;
    logic [LEN_W-1:0] token_length_reg, token_length_next;
    logic             token_bad_reg, token_bad_next;
    logic             halted_reg, halted_next;

    logic             accept;
    logic [7:0]       c_up;
    logic [IDX_W:0]   enc;
    logic [8:0]       look;
    logic             is_ws;
    logic             closes;
    logic [SYM_W-1:0] tb;
    logic [LEN_W-1:0] tl;
    logic             bad;
    logic             halt_c;
    job_t             job;
    logic             job_valid;

    assign accept = in_valid && !q_full;
    assign in_ready = !q_full;
    assign c_up = to_upper(char_in);
    assign enc = encode_index(c_up);
    assign is_ws = (char_in == CHAR_SPACE) || (char_in >= CHAR_TAB && char_in <= CHAR_CR);

    // Classify the byte and work out the token that it leaves
    always_comb
    begin
        job       = '0;
        job_valid = 1'b0;
        tb        = token_bits_reg;
        tl        = token_length_reg;
        bad       = token_bad_reg;
        halt_c    = halted_reg;
        closes    = end_of_message;
        look      = '0;
        if (!mode_reg) begin
            if (!halted_reg) begin
                job_valid = 1'b1;
                if (enc[IDX_W]) begin
                    job.is_sym   = 1'b1;
                    job.sym_bits = CODE_BITS[enc[IDX_W-1:0]];
                    job.sym_len  = CODE_LEN[enc[IDX_W-1:0]];
                end else begin
                    job.kind = KIND_INVALID;
                    job.ch   = c_up;
                    halt_c   = 1'b1;
                end
            end
        end else begin
            if (char_in == CHAR_DOT || char_in == CHAR_DASH) begin
                if (tl >= LEN_W'(MAX_SYMBOLS)) begin
                    bad = 1'b1;
                end else begin
                    if (char_in == CHAR_DASH)
                        tb[tl] = 1'b1;
                    tl = tl + LEN_W'(1);
                end
            end else if (is_ws) begin
                closes = 1'b1;
            end else begin
                bad = 1'b1;
            end
            if (closes) begin
                look      = decode_lookup(tb, tl);
                job_valid = 1'b1;
                if (!bad && tl != '0 && look[8]) begin
                    job.kind = KIND_CHAR;
                    job.ch   = look[7:0];
                end else begin
                    job.kind = KIND_INVALID;
                    job.ch   = '0;
                end
                tb  = '0;
                tl  = '0;
                bad = 1'b0;
            end
        end
        if (end_of_message)
            halt_c = 1'b0;
    end

    // Commit token and halt state only on a transfer; mode on a config write
    always_comb
    begin
        mode_next         = cfg_we ? cfg_wdata : mode_reg;
        token_bits_next   = accept ? tb : token_bits_reg;
        token_length_next = accept ? tl : token_length_reg;
        token_bad_next    = accept ? bad : token_bad_reg;
        halted_next       = accept ? halt_c : halted_reg;
    end

    assign push_valid = accept && job_valid;
    assign push_job   = job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg         <= 1'b0;
            token_bits_reg   <= '0;
            token_length_reg <= '0;
            token_bad_reg    <= 1'b0;
            halted_reg       <= 1'b0;
        end else begin
            mode_reg         <= mode_next;
            token_bits_reg   <= token_bits_next;
            token_length_reg <= token_length_next;
            token_bad_reg    <= token_bad_next;
            halted_reg       <= halted_next;
        end
    end

endmodule

// ===== hdl/mct_queue.sv =====
// Short job queue decoupling the front end from the back end.
module mct_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  mct_pkg::job_t push_job,
    input  logic          pop,
    output mct_pkg::job_t head_job,
    output logic          full,
    output logic          empty
);
    import mct_pkg::*;

    job_t              slots_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_job = slots_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + QCNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store payload; no reset needed
    always_ff @(posedge clk)
    begin
        if (do_push)
            slots_reg[wr_ptr_reg] <= push_job;
    end

endmodule

// ===== hdl/mct_back.sv =====
// Back end: jobs become results in an output register, one per cycle unless stalled.
module mct_back (
    input  logic          clk,
    input  logic          rst_n,
    input  mct_pkg::job_t head_job,
    input  logic          q_empty,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [1:0]    kind,
    output logic [7:0]    char_out,
    output logic          last
);
    import mct_pkg::*;

    logic             out_valid_reg, out_valid_next;
    kind_t            kind_reg, kind_next;
    logic [7:0]       char_reg, char_next;
    logic             last_reg, last_next;
    logic [LEN_W-1:0] idx_reg, idx_next;
    logic             load;
    logic             is_last;

    assign load = !out_valid_reg || out_ready;

    // Pick the next result from the head job
    always_comb
    begin
        out_valid_next = out_valid_reg;
        kind_next      = kind_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        idx_next       = idx_reg;
        is_last        = 1'b0;
        pop            = 1'b0;
        if (load) begin
            out_valid_next = !q_empty;
            if (!q_empty) begin
                if (head_job.is_sym) begin
                    is_last   = (idx_reg == LEN_W'(head_job.sym_len - LEN_W'(1)));
                    kind_next = head_job.sym_bits[idx_reg] ? KIND_DASH : KIND_DOT;
                    char_next = '0;
                end else begin
                    is_last   = 1'b1;
                    kind_next = head_job.kind;
                    char_next = head_job.ch;
                end
                last_next = is_last;
                pop       = is_last;
                idx_next  = is_last ? '0 : idx_reg + LEN_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end else begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    // Hold payload while stalled
    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign char_out  = char_reg;
    assign last      = last_reg;

endmodule
